>>> rtl/priority_sorted_task_table_top_macros.svh
// Assertion macros used by the table top
`ifndef PRIORITY_SORTED_TASK_TABLE_TOP_MACROS_SVH
`define PRIORITY_SORTED_TASK_TABLE_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define PSTT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pstt check failed");

// Check that cons holds in the cycle after ante
`define PSTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pstt check failed");

`endif

>>> rtl/pstt_pkg.sv
`timescale 1ns / 1ps
package pstt_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  // Operation codes of the func field
  localparam logic [3:0] FUNC_UPSERT   = 4'd0;
  localparam logic [3:0] FUNC_REMOVE   = 4'd1;
  localparam logic [3:0] FUNC_SEL_IDX  = 4'd2;
  localparam logic [3:0] FUNC_SEL_KEY  = 4'd3;
  localparam logic [3:0] FUNC_MOVE     = 4'd4;
  localparam logic [3:0] FUNC_NEXT_ATT = 4'd5;
  localparam logic [3:0] FUNC_STALE    = 4'd6;
  localparam logic [3:0] FUNC_CLEAR    = 4'd7;
  localparam logic [3:0] FUNC_RD_IDX   = 4'd8;
  localparam logic [3:0] FUNC_RD_SEL   = 4'd9;

  // Status codes
  localparam logic [2:0] ST_WAIT_INPUT = 3'd3;
  localparam logic [2:0] ST_RUNNING    = 3'd1;
  localparam logic [2:0] ST_DONE       = 3'd4;
  localparam logic [2:0] ST_CANCELLED  = 3'd6;
  localparam logic [2:0] ST_STALE      = 3'd7;

  typedef struct packed {
    logic [3:0]        func;
    logic [63:0]       task_key;
    logic [2:0]        task_status;
    logic              needs_attention;
    logic [63:0]       updated_stamp;
    logic [63:0]       task_payload;
    logic [7:0]        entry_index;
    logic signed [7:0] move_delta;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic        entry_valid;
    logic [63:0] entry_key;
    logic [2:0]  entry_status;
    logic        entry_attention;
    logic [63:0] entry_stamp;
    logic [63:0] entry_payload;
    logic [4:0]  task_count;
    logic [4:0]  clearable_count;
    logic [3:0]  selected_index;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_UPSERT, S_SORT, S_SHIFT, S_MOVE,
    S_ATTN, S_STALE, S_CNT_INIT, S_CNT, S_FIN
  } ctl_state_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_SCAN, CMD_UPSERT_WR, CMD_SWAP, CMD_SORT_NEXT,
    CMD_SHIFT_INIT, CMD_SHIFT, CMD_REM_FIN, CMD_SEL_KEY, CMD_SEL_IDX,
    CMD_MOVE_INIT, CMD_MOVE_STEP, CMD_MOVE_SET, CMD_ATTN_INIT, CMD_ATTN_STEP,
    CMD_ATTN_FIN, CMD_SWEEP_INIT, CMD_STALE, CMD_CLEAR, CMD_CNT_INIT, CMD_CNT,
    CMD_OUT
  } dp_cmd_e;

  typedef struct packed {
    logic [3:0] func;
    logic       found;
    logic       scan_end;
    logic       empty;
    logic       wr_ok;
    logic       sort_done;
    logic       swap_go;
    logic       shift_end;
    logic       mod_ok;
    logic       attn_end;
    logic       sweep_end;
  } dp_status_t;

endpackage

>>> rtl/pstt_in_if.sv
`timescale 1ns / 1ps
interface pstt_in_if;
  logic           valid;
  logic           ready;
  pstt_pkg::req_t req;
  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

>>> rtl/pstt_out_if.sv
`timescale 1ns / 1ps
interface pstt_out_if;
  logic           valid;
  logic           ready;
  pstt_pkg::rsp_t rsp;
  modport source (output valid, output rsp, input ready);
  modport sink   (input valid, input rsp, output ready);
endinterface

>>> rtl/pstt_ctrl.sv
`timescale 1ns / 1ps
module pstt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  pstt_pkg::dp_status_t st_i,
  output pstt_pkg::dp_cmd_e    cmd_o
);
  import pstt_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        case (st_i.func) inside
          FUNC_UPSERT, FUNC_REMOVE, FUNC_SEL_KEY: state_d = S_SCAN;
          FUNC_MOVE:     state_d = st_i.empty ? S_CNT_INIT : S_MOVE;
          FUNC_NEXT_ATT: state_d = st_i.empty ? S_CNT_INIT : S_ATTN;
          FUNC_STALE:    state_d = S_STALE;
          default:       state_d = S_CNT_INIT;
        endcase
      end
      S_SCAN: begin
        if (st_i.scan_end) begin
          if (st_i.func == FUNC_UPSERT) state_d = S_UPSERT;
          else if (st_i.func == FUNC_REMOVE && st_i.found) state_d = S_SHIFT;
          else state_d = S_CNT_INIT;
        end
      end
      S_UPSERT:   state_d = st_i.wr_ok ? S_SORT : S_CNT_INIT;
      S_SORT:     if (st_i.sort_done) state_d = S_CNT_INIT;
      S_SHIFT:    if (st_i.shift_end) state_d = S_CNT_INIT;
      S_MOVE:     if (st_i.mod_ok) state_d = S_CNT_INIT;
      S_ATTN:     if (st_i.attn_end) state_d = S_CNT_INIT;
      S_STALE:    if (st_i.sweep_end) state_d = S_CNT_INIT;
      S_CNT_INIT: state_d = S_CNT;
      S_CNT:      if (st_i.sweep_end) state_d = S_FIN;
      S_FIN:      if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o = CMD_NONE;
    unique case (state_q)
      S_IDLE: if (in_valid_i) cmd_o = CMD_LOAD;
      S_DISPATCH: begin
        case (st_i.func)
          FUNC_SEL_IDX:  cmd_o = CMD_SEL_IDX;
          FUNC_MOVE:     cmd_o = st_i.empty ? CMD_NONE : CMD_MOVE_INIT;
          FUNC_NEXT_ATT: cmd_o = st_i.empty ? CMD_NONE : CMD_ATTN_INIT;
          FUNC_STALE:    cmd_o = CMD_SWEEP_INIT;
          FUNC_CLEAR:    cmd_o = CMD_CLEAR;
          default:       cmd_o = CMD_NONE;
        endcase
      end
      S_SCAN: begin
        if (!st_i.scan_end) cmd_o = CMD_SCAN;
        else if (st_i.func == FUNC_REMOVE && st_i.found) cmd_o = CMD_SHIFT_INIT;
        else if (st_i.func == FUNC_SEL_KEY) cmd_o = CMD_SEL_KEY;
      end
      S_UPSERT: cmd_o = CMD_UPSERT_WR;
      S_SORT: begin
        if (!st_i.sort_done) cmd_o = st_i.swap_go ? CMD_SWAP : CMD_SORT_NEXT;
      end
      S_SHIFT:    cmd_o = st_i.shift_end ? CMD_REM_FIN : CMD_SHIFT;
      S_MOVE:     cmd_o = st_i.mod_ok ? CMD_MOVE_SET : CMD_MOVE_STEP;
      S_ATTN:     cmd_o = st_i.attn_end ? CMD_ATTN_FIN : CMD_ATTN_STEP;
      S_STALE:    if (!st_i.sweep_end) cmd_o = CMD_STALE;
      S_CNT_INIT: cmd_o = CMD_CNT_INIT;
      S_CNT:      if (!st_i.sweep_end) cmd_o = CMD_CNT;
      S_FIN:      if (out_free) cmd_o = CMD_OUT;
      default:    cmd_o = CMD_NONE;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (state_q == S_FIN && out_free) out_valid_d = 1'b1;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/pstt_dp.sv
`timescale 1ns / 1ps
module pstt_dp #(
  parameter int MAX_ENTRIES = pstt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pstt_pkg::dp_cmd_e    cmd_i,
  input  pstt_pkg::req_t       req_i,
  output pstt_pkg::dp_status_t st_o,
  output pstt_pkg::rsp_t       rsp_o
);
  import pstt_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  // Entry stores
  logic [63:0] key_mem   [MAX_ENTRIES];
  logic [2:0]  stat_mem  [MAX_ENTRIES];
  logic        attn_mem  [MAX_ENTRIES];
  logic [63:0] stamp_mem [MAX_ENTRIES];
  logic [63:0] pay_mem   [MAX_ENTRIES];

  req_t              req_q;
  rsp_t              rsp_q;
  logic [CW-1:0]     total_q, i_q, j_q, pos_q, cnt_q;
  logic [IW-1:0]     cursor_q;
  logic              found_q, ok_q;
  logic signed [9:0] n_q;

  logic [IW-1:0]     i_idx, i1_idx, j_idx, jm_idx, pos_idx, wr_idx;
  logic [CW-1:0]     i_inc, j_inc, total_dec;
  logic              ranks, sel_valid, rd_valid;
  logic signed [9:0] tot_s;
  logic [IW-1:0]     rd_idx;

  assign i_inc     = i_q + CW'(1);
  assign j_inc     = j_q + CW'(1);
  assign total_dec = total_q - CW'(1);
  assign i_idx     = i_q[IW-1:0];
  assign i1_idx    = i_inc[IW-1:0];
  assign j_idx     = j_q[IW-1:0];
  assign jm_idx    = j_idx - IW'(1);
  assign pos_idx   = pos_q[IW-1:0];
  assign wr_idx    = found_q ? pos_idx : total_q[IW-1:0];
  assign tot_s     = 10'(signed'({1'b0, total_q}));
  assign sel_valid = CW'(cursor_q) < total_q;

  // Compare entry j against its upper neighbor
  always_comb begin
    if (attn_mem[j_idx] != attn_mem[jm_idx]) begin
      ranks = attn_mem[j_idx];
    end else if ((stat_mem[j_idx] == ST_RUNNING) != (stat_mem[jm_idx] == ST_RUNNING)) begin
      ranks = (stat_mem[j_idx] == ST_RUNNING);
    end else begin
      ranks = stamp_mem[j_idx] > stamp_mem[jm_idx];
    end
  end

  // Pick the entry to read
  always_comb begin
    rd_idx   = cursor_q;
    rd_valid = 1'b0;
    if (req_q.func == FUNC_RD_IDX) begin
      rd_idx   = req_q.entry_index[IW-1:0];
      rd_valid = req_q.entry_index < 8'(total_q);
    end else if (req_q.func == FUNC_RD_SEL) begin
      rd_valid = sel_valid;
    end
  end

  always_comb begin
    st_o.func      = req_q.func;
    st_o.found     = found_q;
    st_o.scan_end  = found_q || (i_q == total_q);
    st_o.empty     = (total_q == '0);
    st_o.wr_ok     = found_q || (total_q < CW'(MAX_ENTRIES));
    st_o.sort_done = (i_q >= total_q);
    st_o.swap_go   = (j_q != '0) && ranks;
    st_o.shift_end = (i_inc >= total_q);
    st_o.mod_ok    = (n_q >= 10'sd0) && (n_q < tot_s);
    st_o.attn_end  = found_q || (i_q == total_q);
    st_o.sweep_end = (i_q == total_q);
  end

  // Store updates
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_UPSERT_WR: begin
        if (found_q || total_q < CW'(MAX_ENTRIES)) begin
          key_mem[wr_idx]   <= req_q.task_key;
          stat_mem[wr_idx]  <= req_q.task_status;
          attn_mem[wr_idx]  <= req_q.needs_attention;
          stamp_mem[wr_idx] <= req_q.updated_stamp;
          pay_mem[wr_idx]   <= req_q.task_payload;
        end
      end
      CMD_SWAP: begin
        key_mem[j_idx]    <= key_mem[jm_idx];
        stat_mem[j_idx]   <= stat_mem[jm_idx];
        attn_mem[j_idx]   <= attn_mem[jm_idx];
        stamp_mem[j_idx]  <= stamp_mem[jm_idx];
        pay_mem[j_idx]    <= pay_mem[jm_idx];
        key_mem[jm_idx]   <= key_mem[j_idx];
        stat_mem[jm_idx]  <= stat_mem[j_idx];
        attn_mem[jm_idx]  <= attn_mem[j_idx];
        stamp_mem[jm_idx] <= stamp_mem[j_idx];
        pay_mem[jm_idx]   <= pay_mem[j_idx];
      end
      CMD_SHIFT: begin
        key_mem[i_idx]   <= key_mem[i1_idx];
        stat_mem[i_idx]  <= stat_mem[i1_idx];
        attn_mem[i_idx]  <= attn_mem[i1_idx];
        stamp_mem[i_idx] <= stamp_mem[i1_idx];
        pay_mem[i_idx]   <= pay_mem[i1_idx];
      end
      CMD_STALE: begin
        if (stat_mem[i_idx] <= ST_WAIT_INPUT) begin
          stat_mem[i_idx] <= ST_STALE;
          attn_mem[i_idx] <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Latch the item and drive the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) req_q <= req_i;
    if (cmd_i == CMD_OUT) begin
      rsp_q.ok              <= (req_q.func == FUNC_RD_IDX || req_q.func == FUNC_RD_SEL)
                               ? rd_valid : ok_q;
      rsp_q.entry_valid     <= rd_valid;
      rsp_q.entry_key       <= rd_valid ? key_mem[rd_idx] : '0;
      rsp_q.entry_status    <= rd_valid ? stat_mem[rd_idx] : '0;
      rsp_q.entry_attention <= rd_valid ? attn_mem[rd_idx] : 1'b0;
      rsp_q.entry_stamp     <= rd_valid ? stamp_mem[rd_idx] : '0;
      rsp_q.entry_payload   <= rd_valid ? pay_mem[rd_idx] : '0;
      rsp_q.task_count      <= 5'(total_q);
      rsp_q.clearable_count <= 5'(cnt_q);
      rsp_q.selected_index  <= 4'(cursor_q);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      cursor_q <= '0;
      i_q      <= '0;
      j_q      <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      ok_q     <= 1'b0;
      n_q      <= '0;
    end else begin
      unique case (cmd_i)
        CMD_LOAD: begin
          i_q     <= '0;
          found_q <= 1'b0;
          ok_q    <= 1'b0;
        end
        CMD_SCAN: begin
          if (key_mem[i_idx] == req_q.task_key) begin
            found_q <= 1'b1;
            pos_q   <= i_q;
          end else begin
            i_q <= i_inc;
          end
        end
        CMD_UPSERT_WR: begin
          if (found_q) begin
            ok_q <= 1'b1;
          end else if (total_q < CW'(MAX_ENTRIES)) begin
            ok_q    <= 1'b1;
            total_q <= total_q + CW'(1);
          end
          i_q <= CW'(1);
          j_q <= CW'(1);
        end
        CMD_SWAP: begin
          // follow the selected entry through the swap
          if (sel_valid && cursor_q == j_idx) cursor_q <= jm_idx;
          else if (sel_valid && cursor_q == jm_idx) cursor_q <= j_idx;
          j_q <= j_q - CW'(1);
        end
        CMD_SORT_NEXT: begin
          i_q <= i_inc;
          j_q <= i_inc;
        end
        CMD_SHIFT_INIT: begin
          i_q  <= pos_q;
          ok_q <= 1'b1;
        end
        CMD_SHIFT: i_q <= i_inc;
        CMD_REM_FIN: begin
          total_q <= total_dec;
          if (total_dec == '0) begin
            cursor_q <= '0;
          end else if (sel_valid && cursor_q == pos_idx) begin
            cursor_q <= (pos_q < total_dec) ? pos_idx : IW'(total_dec - CW'(1));
          end else if (sel_valid && CW'(cursor_q) > pos_q) begin
            cursor_q <= cursor_q - IW'(1);
          end
        end
        CMD_SEL_KEY: begin
          if (found_q) begin
            cursor_q <= pos_idx;
            ok_q     <= 1'b1;
          end
        end
        CMD_SEL_IDX: begin
          if (req_q.entry_index < 8'(total_q)) begin
            cursor_q <= req_q.entry_index[IW-1:0];
            ok_q     <= 1'b1;
          end
        end
        CMD_MOVE_INIT: n_q <= 10'(signed'({1'b0, cursor_q})) + 10'(req_q.move_delta);
        CMD_MOVE_STEP: n_q <= (n_q < 10'sd0) ? n_q + tot_s : n_q - tot_s;
        CMD_MOVE_SET: begin
          cursor_q <= n_q[IW-1:0];
          ok_q     <= 1'b1;
        end
        CMD_ATTN_INIT: begin
          i_q  <= '0;
          j_q  <= (CW'(cursor_q) + CW'(1) == total_q) ? '0 : CW'(cursor_q) + CW'(1);
          ok_q <= 1'b1;
        end
        CMD_ATTN_STEP: begin
          if (attn_mem[j_idx]) begin
            found_q <= 1'b1;
          end else begin
            j_q <= (j_inc == total_q) ? '0 : j_inc;
            i_q <= i_inc;
          end
        end
        // without a hit the probe has come back to one past the cursor
        CMD_ATTN_FIN: cursor_q <= j_idx;
        CMD_SWEEP_INIT: begin
          i_q  <= '0;
          ok_q <= 1'b1;
        end
        CMD_STALE: i_q <= i_inc;
        CMD_CLEAR: begin
          total_q  <= '0;
          cursor_q <= '0;
          ok_q     <= 1'b1;
        end
        CMD_CNT_INIT: begin
          i_q   <= '0;
          cnt_q <= '0;
        end
        CMD_CNT: begin
          if (stat_mem[i_idx] >= ST_DONE && stat_mem[i_idx] <= ST_CANCELLED) begin
            cnt_q <= cnt_q + CW'(1);
          end
          i_q <= i_inc;
        end
        default: ;
      endcase
    end
  end

  assign rsp_o = rsp_q;

endmodule

>>> rtl/priority_sorted_task_table_top.sv
`timescale 1ns / 1ps
// Sorted task table: one item in, one result out, one item at a time. An item
// walks the entries one at a time: the key scan (up to MAX_ENTRIES entries),
// the insertion sort after an upsert, the remove shift, the attention search
// or the stale sweep, and a final pass over all entries that counts
// clearable tasks. Move wraps the cursor by repeated add or subtract of the
// entry count. The block takes a new item while the previous result still
// waits in the output register.
`include "priority_sorted_task_table_top_macros.svh"
module priority_sorted_task_table_top #(
  parameter int MAX_ENTRIES = pstt_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pstt_in_if.sink     in_i,
  pstt_out_if.source  out_o
);
  import pstt_pkg::*;

  dp_cmd_e    cmd;
  dp_status_t st;

  pstt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  pstt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_i.req),
    .st_o   (st),
    .rsp_o  (out_o.rsp)
  );

  // Busy right after an item is taken
  `PSTT_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready)
  // A result is presented right after the datapath loads it
  `PSTT_ASSERT_NEXT(a_out_after_load, cmd == CMD_OUT, out_o.valid)
  // A valid read always reports success
  `PSTT_ASSERT_SAME(a_read_ok, out_o.valid && out_o.rsp.entry_valid, out_o.rsp.ok)

endmodule

>>> bench/tb_pstt_if.sv
`timescale 1ns / 1ps
// Bench copies of the item channels live in the RTL; nothing extra needed here.
// Bench constants for the task table.
package tb_pstt_pkg;
  localparam int TABLE_DEPTH = 16;
endpackage

>>> bench/tb_priority_sorted_task_table_top.sv
`timescale 1ns / 1ps
module tb_priority_sorted_task_table_top;
  import pstt_pkg::*;

  localparam int DEPTH = tb_pstt_pkg::TABLE_DEPTH;
  localparam int CYCLE_LIMIT = 3000000;

  // Predictor of the sorted table and queue of expected results
  class table_scoreboard;
    logic [63:0] keys[DEPTH];
    logic [2:0]  stats[DEPTH];
    logic        attns[DEPTH];
    logic [63:0] stamps[DEPTH];
    logic [63:0] pays[DEPTH];
    int          total;
    int          sel;
    rsp_t        pending[$];
    int          errors;

    function void wipe();
      for (int i = 0; i < DEPTH; i++) begin
        keys[i] = '0; stats[i] = '0; attns[i] = 0; stamps[i] = '0; pays[i] = '0;
      end
      total = 0;
      sel = 0;
    endfunction

    function bit outranks(int a, int b);
      if (attns[a] != attns[b]) return attns[a];
      if ((stats[a] == ST_RUNNING) != (stats[b] == ST_RUNNING))
        return stats[a] == ST_RUNNING;
      return stamps[a] > stamps[b];
    endfunction

    function void swap_at(int a, int b);
      logic [63:0] k, s, p;
      logic [2:0]  st;
      logic        at;
      k = keys[a]; s = stamps[a]; p = pays[a]; st = stats[a]; at = attns[a];
      keys[a] = keys[b]; stamps[a] = stamps[b]; pays[a] = pays[b];
      stats[a] = stats[b]; attns[a] = attns[b];
      keys[b] = k; stamps[b] = s; pays[b] = p; stats[b] = st; attns[b] = at;
    endfunction

    function int locate(logic [63:0] k);
      for (int i = 0; i < total; i++) if (keys[i] == k) return i;
      return -1;
    endfunction

    function void wrap_step(int delta);
      int n;
      n = (sel + delta) % total;
      if (n < 0) n += total;
      sel = n;
    endfunction

    // Note one accepted item and queue the result it causes
    function void note_request(req_t r);
      rsp_t        e;
      int          pos, j, f;
      bit          had;
      logic [63:0] sk;
      e = '0;
      pos = 0;
      case (r.func)
        FUNC_UPSERT: begin
          pos = locate(r.task_key);
          if (pos < 0 && total < DEPTH) begin
            pos = total;
            total++;
          end
          if (pos >= 0) begin
            e.ok = 1;
            keys[pos] = r.task_key; stats[pos] = r.task_status;
            attns[pos] = r.needs_attention; stamps[pos] = r.updated_stamp;
            pays[pos] = r.task_payload;
            had = sel < total;
            sk = had ? keys[sel] : '0;
            for (int i = 1; i < total; i++) begin
              j = i;
              while (j > 0 && outranks(j, j - 1)) begin
                swap_at(j, j - 1);
                j--;
              end
            end
            if (had) begin
              f = locate(sk);
              if (f >= 0) sel = f;
            end
          end
        end
        FUNC_REMOVE: begin
          had = sel < total;
          sk = had ? keys[sel] : '0;
          pos = locate(r.task_key);
          if (pos >= 0) begin
            e.ok = 1;
            for (int i = pos; i + 1 < total; i++) begin
              keys[i] = keys[i+1]; stats[i] = stats[i+1]; attns[i] = attns[i+1];
              stamps[i] = stamps[i+1]; pays[i] = pays[i+1];
            end
            total--;
            if (total == 0) sel = 0;
            else if (had && sk == r.task_key) sel = (pos < total) ? pos : total - 1;
            else if (had) begin
              f = locate(sk);
              if (f >= 0) sel = f;
            end
          end
        end
        FUNC_SEL_IDX: if (r.entry_index < total) begin
          sel = r.entry_index;
          e.ok = 1;
        end
        FUNC_SEL_KEY: begin
          pos = locate(r.task_key);
          if (pos >= 0) begin
            sel = pos;
            e.ok = 1;
          end
        end
        FUNC_MOVE: if (total != 0) begin
          wrap_step(int'(r.move_delta));
          e.ok = 1;
        end
        FUNC_NEXT_ATT: if (total != 0) begin
          e.ok = 1;
          f = -1;
          for (int i = 1; i <= total; i++) begin
            if (f < 0 && attns[(sel + i) % total]) f = (sel + i) % total;
          end
          if (f >= 0) sel = f;
          else wrap_step(1);
        end
        FUNC_STALE: begin
          for (int i = 0; i < total; i++) begin
            if (stats[i] <= ST_WAIT_INPUT) begin
              stats[i] = ST_STALE;
              attns[i] = 0;
            end
          end
          e.ok = 1;
        end
        FUNC_CLEAR: begin
          wipe();
          e.ok = 1;
        end
        FUNC_RD_IDX, FUNC_RD_SEL: begin
          pos = (r.func == FUNC_RD_IDX) ? int'(r.entry_index) : sel;
          if (pos < total) begin
            e.ok = 1;
            e.entry_valid = 1;
            e.entry_key = keys[pos];
            e.entry_status = stats[pos];
            e.entry_attention = attns[pos];
            e.entry_stamp = stamps[pos];
            e.entry_payload = pays[pos];
          end
        end
        default: ;
      endcase
      for (int i = 0; i < total; i++)
        if (stats[i] >= ST_DONE && stats[i] <= ST_CANCELLED) e.clearable_count++;
      e.task_count = 5'(total);
      e.selected_index = 4'(sel);
      pending.push_back(e);
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(rsp_t a);
      rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.ok !== e.ok || a.entry_valid !== e.entry_valid ||
          a.entry_key !== e.entry_key || a.entry_status !== e.entry_status ||
          a.entry_attention !== e.entry_attention || a.entry_stamp !== e.entry_stamp ||
          a.entry_payload !== e.entry_payload || a.task_count !== e.task_count ||
          a.clearable_count !== e.clearable_count ||
          a.selected_index !== e.selected_index) begin
        $display("%0t: mismatch expected %p actual %p", $realtime, e, a);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  pstt_in_if  in_ch();
  pstt_out_if out_ch();

  priority_sorted_task_table_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  table_scoreboard board;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;
  longint      cycles;
  logic [63:0] key_pool[8];

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on total run length
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls plus an optional long hold-off
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) board.check_result(out_ch.rsp);
  end

  // Offer one item and wait until it is accepted; the next call replaces or drops it
  task automatic send_item(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.req <= r;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_request(r);
    @(negedge clk_i);
  endtask

  function automatic req_t make_item(logic [3:0] fn);
    req_t r;
    r.func = fn;
    r.task_key = ($urandom_range(3) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(7)];
    r.task_status = 3'($urandom_range(7));
    r.needs_attention = 1'($urandom_range(1));
    r.updated_stamp = ($urandom_range(3) == 0) ? 64'($urandom_range(7)) : {$urandom, $urandom};
    r.task_payload = {$urandom, $urandom};
    r.entry_index = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(17));
    r.move_delta = ($urandom_range(1) == 0) ? 8'($urandom) : 8'($urandom_range(6) - 3);
    return r;
  endfunction

  // Random item mix weighted toward upserts so the table fills
  function automatic logic [3:0] pick_func();
    int w;
    w = $urandom_range(99);
    if (w < 35) return FUNC_UPSERT;
    if (w < 45) return FUNC_REMOVE;
    if (w < 50) return FUNC_SEL_IDX;
    if (w < 55) return FUNC_SEL_KEY;
    if (w < 62) return FUNC_MOVE;
    if (w < 67) return FUNC_NEXT_ATT;
    if (w < 69) return FUNC_STALE;
    if (w < 71) return FUNC_CLEAR;
    if (w < 83) return FUNC_RD_IDX;
    if (w < 97) return FUNC_RD_SEL;
    return 4'($urandom_range(15, 10));
  endfunction

  task automatic wait_drain();
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    req_t r;
    board = new();
    board.wipe();
    board.errors = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    in_ch.valid = 0;
    in_ch.req = '0;
    rst_ni = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: empty-table cases, extremes, a run of upserts, every operation
    for (int f = 0; f < 10; f++) send_item(make_item(4'(f)));
    r = '0; r.func = FUNC_UPSERT; r.task_key = '1; r.task_status = 3'd7;
    r.needs_attention = 1; r.updated_stamp = '1; r.task_payload = '1;
    send_item(r);
    r.func = FUNC_MOVE; r.move_delta = -8'sd128; send_item(r);
    r.move_delta = 8'sd127; send_item(r);
    r.func = FUNC_RD_IDX; r.entry_index = 8'hFF; send_item(r);
    r.entry_index = 0; send_item(r);
    for (int i = 0; i < 18; i++) send_item(make_item(FUNC_UPSERT));
    r.func = FUNC_SEL_IDX; r.entry_index = 8'd15; send_item(r);
    r.func = FUNC_REMOVE; r.task_key = '1; send_item(r);
    r.func = FUNC_NEXT_ATT; send_item(r);
    r.func = FUNC_STALE; send_item(r);
    r.func = FUNC_NEXT_ATT; send_item(r);
    r.func = 4'd15; send_item(r);

    // Random phases with different idling, long hold-off in the first
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 76 : 0;
      recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 24 : 0;
      if (ph == 0) hold_cycles = 3000;
      for (int n = 0; n < 630; n++) send_item(make_item(pick_func()));
    end

    // Drop the last item before the block returns to idle
    in_ch.valid <= 0;
    wait_drain();
    repeat (400) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/pstt_pkg.sv
rtl/pstt_in_if.sv
rtl/pstt_out_if.sv
rtl/pstt_ctrl.sv
rtl/pstt_dp.sv
rtl/priority_sorted_task_table_top.sv
bench/tb_pstt_if.sv
bench/tb_priority_sorted_task_table_top.sv
